/* rtl/spectral_plane_covariance_accumulator_assert.svh */
// Assertion macros for the spectral plane covariance accumulator.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SPECTRAL_PLANE_COVARIANCE_ACCUMULATOR_ASSERT_SVH
`define SPECTRAL_PLANE_COVARIANCE_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPCA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SPCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SPCA_ASSERT_SAME(label, ante, cons)
`define SPCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/spca_pkg.sv */
// Shared types and constants for the spectral plane covariance accumulator.
// No dependencies.
`default_nettype none

package spca_pkg;

    localparam int PLANES   = 128;
    localparam int PLANE_W  = 7;
    localparam int X_W      = 10;
    localparam int Z_W      = 10;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int NORM_W   = PROD_W + 1;
    localparam int ADD_W    = NORM_W + 1;
    localparam int ACC_W    = 64;
    localparam int ENTRY_W  = ACC_W + 1;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic REG_Z_NYQ = 1'b0;
    localparam logic [Z_W-1:0] Z_NYQ_RESET = 10'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_ACC
    } t_state;

    typedef enum logic [1:0] {
        W_ZERO,
        W_ONE,
        W_TWO
    } t_weight;

    typedef struct packed {
        logic    mul_en;
        logic    sum_en;
        t_weight weight;
    } t_mac_ctrl;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             clip;
        logic             write;
    } t_mac_result;

endpackage

`default_nettype wire

/* rtl/spca_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module spca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read data holds until the next read enable.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/spca_mac.sv */
// Weighted multiply and saturating accumulate datapath.
// Depends on spca_pkg.
`default_nettype none

module spca_mac (
    input  wire logic                              i_clk,
    input  wire spca_pkg::t_mac_ctrl               i_ctrl,
    input  wire logic signed [spca_pkg::COEF_W-1:0] i_a_re,
    input  wire logic signed [spca_pkg::COEF_W-1:0] i_a_im,
    input  wire logic signed [spca_pkg::COEF_W-1:0] i_b_re,
    input  wire logic signed [spca_pkg::COEF_W-1:0] i_b_im,
    input  wire logic        [spca_pkg::ACC_W-1:0]  i_old_acc,
    input  wire logic                              i_old_clip,
    output spca_pkg::t_mac_result                  o_result
);
    import spca_pkg::*;

    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;
    t_weight                  r_weight_m;
    logic        [ADD_W-1:0]  r_add;
    t_weight                  r_weight_s;
    logic        [NORM_W-1:0] w_norm;
    logic        [ACC_W:0]    w_sum;

    // Stage one: the two real products.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod_re  <= i_a_re * i_b_re;
            r_prod_im  <= i_a_im * i_b_im;
            r_weight_m <= i_ctrl.weight;
        end
    end

    assign w_norm = {r_prod_re[PROD_W-1], r_prod_re} + {r_prod_im[PROD_W-1], r_prod_im};

    // Stage two: the weighted addend.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_add      <= (r_weight_m == W_TWO) ? {w_norm, 1'b0} : {w_norm[NORM_W-1], w_norm};
            r_weight_s <= r_weight_m;
        end
    end

    // Stage three: one extra sign bit exposes overflow of the signed sum.
    assign w_sum = {i_old_acc[ACC_W-1], i_old_acc}
                 + {{(ACC_W + 1 - ADD_W){r_add[ADD_W-1]}}, r_add};

    always_comb begin
        o_result.write = (r_weight_s != W_ZERO);
        o_result.clip  = i_old_clip;
        o_result.sum   = w_sum[ACC_W-1:0];
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            o_result.clip = 1'b1;
            o_result.sum  = w_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

/* rtl/spectral_plane_covariance_accumulator.sv */
// Top level of the spectral plane covariance accumulator: control, APB register,
// per-plane valid bits and output register. Depends on spca_pkg, spca_ram, spca_mac
// and the assertion header.
//
//  Channel   Direction  Handshake             Payload
//  input     in         i_valid / o_ready     kind, plane, x_index, z_mode, a/b re/im
//  output    out        o_valid / i_ready     plane_sum, plane_out, saturated
//  config    in         psel/penable/pready   paddr, pwdata, pwrite; prdata back
//
// Each word passes through accept (plane memory read and both products), the
// addend sum, and the saturating add with write back. o_ready stays low until
// the word is through, so only one word is in flight at a time.
// A read word that finds the output register still full waits in the last
// cycle until the register is taken. Reset is synchronous and active low; it
// clears all 128 plane valid bits at once, so no clearing pass is needed.
`default_nettype none

module spectral_plane_covariance_accumulator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input channel.
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_kind,
    input  wire logic        [spca_pkg::PLANE_W-1:0] i_plane,
    input  wire logic        [spca_pkg::X_W-1:0]     i_x_index,
    input  wire logic        [spca_pkg::Z_W-1:0]     i_z_mode,
    input  wire logic signed [spca_pkg::COEF_W-1:0]  i_a_re,
    input  wire logic signed [spca_pkg::COEF_W-1:0]  i_a_im,
    input  wire logic signed [spca_pkg::COEF_W-1:0]  i_b_re,
    input  wire logic signed [spca_pkg::COEF_W-1:0]  i_b_im,
    // Output channel.
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed      [spca_pkg::ACC_W-1:0]   o_plane_sum,
    output logic             [spca_pkg::PLANE_W-1:0] o_plane_out,
    output logic                                     o_saturated,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [spca_pkg::APB_AW-1:0]  paddr,
    input  wire logic        [spca_pkg::APB_DW-1:0]  pwdata,
    output logic             [spca_pkg::APB_DW-1:0]  prdata,
    output logic                                     pready
);
    import spca_pkg::*;

`include "spectral_plane_covariance_accumulator_assert.svh"

    t_state               r_state;
    t_state               n_state;
    logic                 r_kind;
    logic [PLANE_W-1:0]   r_plane;
    logic [Z_W-1:0]       r_z_nyq;
    logic [PLANES-1:0]    r_entry_valid;
    logic                 r_out_valid;
    logic [ACC_W-1:0]     r_out_sum;
    logic [PLANE_W-1:0]   r_out_plane;
    logic                 r_out_sat;

    logic                 w_accept;
    logic                 w_sum_en;
    logic                 w_ram_we;
    logic                 w_out_load;
    logic                 w_cfg_we;
    logic [ENTRY_W-1:0]   w_ram_rdata;
    logic [ACC_W-1:0]     w_old_acc;
    logic                 w_old_clip;
    t_weight              w_weight;
    t_mac_ctrl            w_ctrl;
    t_mac_result          w_result;

    // Configuration register: only the z Nyquist mode lives here.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == REG_Z_NYQ);
    assign prdata   = (paddr[APB_AW-1] == REG_Z_NYQ)
                    ? {{(APB_DW - Z_W){1'b0}}, r_z_nyq} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_nyq <= Z_NYQ_RESET;
        end else if (w_cfg_we) begin
            r_z_nyq <= pwdata[Z_W-1:0];
        end
    end

    // The weight follows the mode class. Modes above Nyquist and the mean add
    // nothing. With a Nyquist index of zero, z zero counts as an edge mode.
    always_comb begin
        if (i_z_mode > r_z_nyq) begin
            w_weight = W_ZERO;
        end else if (i_z_mode == '0 || i_z_mode == r_z_nyq) begin
            w_weight = (i_z_mode == '0 && i_x_index == '0) ? W_ZERO : W_ONE;
        end else begin
            w_weight = W_TWO;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_kind == KIND_ACCUM || !r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_ready    = 1'b0;
        w_sum_en   = 1'b0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_SUM: begin
                w_sum_en = 1'b1;
            end
            ST_ACC: begin
                w_ram_we   = (r_kind == KIND_ACCUM) && w_result.write;
                w_out_load = (r_kind == KIND_READ) && (!r_out_valid || i_ready);
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_valid && o_ready;
    assign w_ctrl   = '{mul_en: w_accept, sum_en: w_sum_en, weight: w_weight};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_plane <= i_plane;
        end
    end

    // A plane whose valid bit is clear reads as a zero sum with no clip.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (w_ram_we) begin
            r_entry_valid[r_plane] <= 1'b1;
        end else if (w_out_load) begin
            r_entry_valid[r_plane] <= 1'b0;
        end
    end

    assign w_old_acc  = r_entry_valid[r_plane] ? w_ram_rdata[ACC_W-1:0] : '0;
    assign w_old_clip = r_entry_valid[r_plane] && w_ram_rdata[ACC_W];

    // Plane memory, one entry per plane holding {clip, sum}. The read issued at
    // accept holds its data through the remaining cycles of that word.
    spca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PLANES)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_plane),
        .i_wdata ({w_result.clip, w_result.sum}),
        .i_re    (w_accept),
        .i_raddr (i_plane),
        .o_rdata (w_ram_rdata)
    );

    spca_mac u_mac (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .i_old_acc  (w_old_acc),
        .i_old_clip (w_old_clip),
        .o_result   (w_result)
    );

    // Output register; it parts the result from the next accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sum   <= w_old_acc;
            r_out_plane <= r_plane;
            r_out_sat   <= w_old_clip;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_plane_sum = r_out_sum;
    assign o_plane_out = r_out_plane;
    assign o_saturated = r_out_sat;

    // An accepted word always moves on to the addend cycle.
    `SPCA_ASSERT_NEXT(a_accept_to_sum, w_accept, r_state == ST_SUM)
    // The plane memory is written only by an accumulate word in its last cycle.
    `SPCA_ASSERT_SAME(a_write_only_accum, w_ram_we, r_state == ST_ACC && r_kind == KIND_ACCUM)
    // A read word lands in the output register with its plane index.
    `SPCA_ASSERT_NEXT(a_read_delivers, w_out_load, o_valid && o_plane_out == $past(r_plane))
    // After a read the plane reads back as cleared.
    `SPCA_ASSERT_NEXT(a_read_clears, w_out_load, r_entry_valid[$past(r_plane)] == 1'b0)

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for spectral_plane_covariance_accumulator.
// Depends on spca_pkg and the accumulator RTL. A queue-fed driver, an output monitor and
// an in-bench covariance predictor check every plane read word.

module tb_top;
    import spca_pkg::*;

    // One input word as the driver presents it on the input channel.
    typedef struct {
        logic                     kind;
        logic [PLANE_W-1:0]       plane;
        logic [X_W-1:0]           x_index;
        logic [Z_W-1:0]           z_mode;
        logic signed [COEF_W-1:0] a_re;
        logic signed [COEF_W-1:0] a_im;
        logic signed [COEF_W-1:0] b_re;
        logic signed [COEF_W-1:0] b_im;
    } cov_word_t;

    // One plane read word as the block should return it.
    typedef struct {
        logic signed [ACC_W-1:0] sum;
        logic [PLANE_W-1:0]      plane;
        logic                    saturated;
    } plane_read_t;

    localparam int     COEF_MAX      = 8388607;
    localparam int     COEF_MIN      = -8388608;
    localparam longint SUM_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN       = 64'h8000_0000_0000_0000;
    localparam int     Z_MAX         = (1 << Z_W) - 1;
    // Covers any word still inside the block and the output register.
    localparam int     SETTLE_CYCLES = 8;
    // Watchdog limit for about 540 words, with idles and stalls.
    localparam int     CYCLE_LIMIT   = 40000;
    // Length of the runs of largest addends into one plane.
    localparam int     LARGE_RUN_WORDS = 16;
    localparam logic [APB_AW-1:0] Z_NYQ_ADDR = APB_AW'(4 * int'(REG_Z_NYQ));

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     i_valid   = 1'b0;
    wire                      o_ready;
    logic                     i_kind    = KIND_ACCUM;
    logic [PLANE_W-1:0]       i_plane   = '0;
    logic [X_W-1:0]           i_x_index = '0;
    logic [Z_W-1:0]           i_z_mode  = '0;
    logic signed [COEF_W-1:0] i_a_re    = '0;
    logic signed [COEF_W-1:0] i_a_im    = '0;
    logic signed [COEF_W-1:0] i_b_re    = '0;
    logic signed [COEF_W-1:0] i_b_im    = '0;
    wire                      o_valid;
    logic                     i_ready   = 1'b0;
    wire signed [ACC_W-1:0]   o_plane_sum;
    wire [PLANE_W-1:0]        o_plane_out;
    wire                      o_saturated;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_AW-1:0]        paddr     = '0;
    logic [APB_DW-1:0]        pwdata    = '0;
    wire [APB_DW-1:0]         prdata;
    wire                      pready;

    spectral_plane_covariance_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_plane     (i_plane),
        .i_x_index   (i_x_index),
        .i_z_mode    (i_z_mode),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_plane_sum (o_plane_sum),
        .o_plane_out (o_plane_out),
        .o_saturated (o_saturated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Words waiting for the driver, and plane reads that the predictor says must come back.
    cov_word_t   pending_words[$];
    plane_read_t expected_reads[$];
    cov_word_t   on_bus;

    // The predictor's own copy of the block state and of the Nyquist register.
    logic signed [ACC_W-1:0] plane_total [PLANES];
    logic                    plane_clip [PLANES];
    logic [Z_W-1:0]          z_nyquist = Z_NYQ_RESET;

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int          mismatch_count    = 0;
    int          cycle_count       = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Applies one accepted word to the predicted plane state. A read word yields the
    // expected result and clears the plane; an accumulate word adds the weighted real
    // part of a * conj(b), held at the 64-bit limits with a sticky clip flag.
    function automatic void model_covariance_word(input cov_word_t w);
        plane_read_t             rd;
        t_weight                 weight;
        longint                  ar, ai, br, bi;
        longint                  norm;
        longint                  addend;
        logic signed [ACC_W:0]   total;
        if (w.kind == KIND_READ) begin
            rd.plane     = w.plane;
            rd.sum       = '0;
            rd.saturated = 1'b0;
            if (int'(w.plane) < PLANES) begin
                rd.sum               = plane_total[w.plane];
                rd.saturated         = plane_clip[w.plane];
                plane_total[w.plane] = '0;
                plane_clip[w.plane]  = 1'b0;
            end
            expected_reads.push_back(rd);
            return;
        end
        // A 10-bit x index never reaches past the 1024-point grid, so only the plane
        // and the z mode can put a word out of range.
        if (int'(w.plane) >= PLANES || w.z_mode > z_nyquist) begin
            return;
        end
        // The mean carries no covariance. The z 0 and Nyquist columns have no mirror
        // image; every interior mode also stands for its negative wavenumber.
        if (w.z_mode == '0 && w.x_index == '0) begin
            weight = W_ZERO;
        end else if (w.z_mode == '0 || w.z_mode == z_nyquist) begin
            weight = W_ONE;
        end else begin
            weight = W_TWO;
        end
        ar   = w.a_re;
        ai   = w.a_im;
        br   = w.b_re;
        bi   = w.b_im;
        norm = ar * br + ai * bi;
        case (weight)
            W_ZERO: return;
            W_ONE:  addend = norm;
            default: addend = norm * 2;
        endcase
        total = plane_total[w.plane];
        total = total + addend;
        if (total > SUM_MAX) begin
            plane_total[w.plane] = SUM_MAX;
            plane_clip[w.plane]  = 1'b1;
        end else if (total < SUM_MIN) begin
            plane_total[w.plane] = SUM_MIN;
            plane_clip[w.plane]  = 1'b1;
        end else begin
            plane_total[w.plane] = total[ACC_W-1:0];
        end
    endfunction

    function automatic cov_word_t make_word(input logic kind, input int plane, input int x,
                                            input int z, input int ar, input int ai,
                                            input int br, input int bi);
        cov_word_t w;
        w.kind    = kind;
        w.plane   = PLANE_W'(plane);
        w.x_index = X_W'(x);
        w.z_mode  = Z_W'(z);
        w.a_re    = COEF_W'(ar);
        w.a_im    = COEF_W'(ai);
        w.b_re    = COEF_W'(br);
        w.b_im    = COEF_W'(bi);
        return w;
    endfunction

    // Coefficients lean toward the extremes so that large products and sign mixes are
    // common; the rest are uniform over the full 24-bit range.
    function automatic int random_coef();
        case ($urandom_range(9))
            0: return COEF_MIN;
            1: return COEF_MAX;
            2: return 0;
            3: return -1;
            default: return int'($signed(COEF_W'($urandom)));
        endcase
    endfunction

    // Most words hit a few busy planes so that reads return real sums. The z mode is
    // spread over the mean column, the Nyquist column, interior modes, modes above the
    // Nyquist register and the full field range.
    function automatic cov_word_t random_word();
        logic kind;
        int   plane, x, z, nyq;
        nyq   = int'(z_nyquist);
        kind  = ($urandom_range(99) < 15) ? KIND_READ : KIND_ACCUM;
        plane = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(PLANES - 1);
        x     = ($urandom_range(99) < 20) ? 0 : $urandom_range((1 << X_W) - 1);
        case ($urandom_range(6))
            0: z = 0;
            1: z = nyq;
            2, 3, 4: z = (nyq > 1) ? $urandom_range(nyq - 1, 1) : nyq;
            5: z = (nyq < Z_MAX) ? $urandom_range(Z_MAX, nyq + 1) : nyq;
            default: z = $urandom_range(Z_MAX);
        endcase
        return make_word(kind, plane, x, z, random_coef(), random_coef(), random_coef(),
                         random_coef());
    endfunction

    task automatic push_random_words(input int count);
        repeat (count) pending_words.push_back(random_word());
    endtask

    // Waits until the driver is empty and every read has come back, then lets any
    // accumulate word still inside the block finish its write back.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || expected_reads.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the Nyquist register, then reads it straight back over the same port.
    task automatic write_z_nyquist(input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= Z_NYQ_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // The register takes the value at this edge; the read setup follows at once.
        z_nyquist = Z_W'(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[Z_W-1:0] !== Z_W'(value)) begin
            report_mismatch($sformatf("Nyquist register read %0d, wrote %0d",
                                      prdata[Z_W-1:0], value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Driver: a new word is loaded whenever the bus is empty or its word is taken at
    // this edge, so valid stays high across back-to-back words. The sender idles at
    // random per the current idle percentage.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                model_covariance_word(on_bus);
            end
            if (!i_valid || o_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    on_bus    = pending_words.pop_front();
                    i_valid   <= 1'b1;
                    i_kind    <= on_bus.kind;
                    i_plane   <= on_bus.plane;
                    i_x_index <= on_bus.x_index;
                    i_z_mode  <= on_bus.z_mode;
                    i_a_re    <= on_bus.a_re;
                    i_a_im    <= on_bus.a_im;
                    i_b_re    <= on_bus.b_re;
                    i_b_im    <= on_bus.b_im;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result word taken is checked against the oldest expected read,
    // and the receiver stalls at random per the current idle percentage.
    always @(posedge i_clk) begin
        plane_read_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for plane %0d", o_plane_out));
                end else begin
                    want = expected_reads.pop_front();
                    if (o_plane_sum !== want.sum) begin
                        report_mismatch($sformatf("plane %0d sum %0d, expected %0d",
                                                  want.plane, o_plane_sum, want.sum));
                    end
                    if (o_plane_out !== want.plane) begin
                        report_mismatch($sformatf("plane_out %0d, expected %0d",
                                                  o_plane_out, want.plane));
                    end
                    if (o_saturated !== want.saturated) begin
                        report_mismatch($sformatf("plane %0d saturated %0b, expected %0b",
                                                  want.plane, o_saturated, want.saturated));
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("spectral_plane_covariance_accumulator regression: fail");
        $finish;
    end

    initial begin
        for (int p = 0; p < PLANES; p++) begin
            plane_total[p] = '0;
            plane_clip[p]  = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: a sender that rarely idles against a receiver that often stalls.
        sender_idle_pct   = 11;
        receiver_idle_pct = 45;

        // Directed words at the reset Nyquist mode of 32: a fresh plane reads zero, the
        // mean adds nothing, z 0 and Nyquist count once, interior modes twice, modes
        // above Nyquist are dropped, and a read clears the plane.
        pending_words.push_back(make_word(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_ACCUM, 1, 0, 0,
                                          COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
        pending_words.push_back(make_word(KIND_ACCUM, 1, 5, 0,
                                          COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
        pending_words.push_back(make_word(KIND_ACCUM, 1, 1023, 32,
                                          COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
        pending_words.push_back(make_word(KIND_ACCUM, 1, 0, 1, COEF_MAX, COEF_MIN, -1, COEF_MAX));
        pending_words.push_back(make_word(KIND_ACCUM, 1, 9, 33, COEF_MAX, 5, COEF_MAX, 7));
        pending_words.push_back(make_word(KIND_ACCUM, 1, 9, Z_MAX, COEF_MIN, 3, COEF_MIN, 2));
        pending_words.push_back(make_word(KIND_READ, 1, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 1, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_ACCUM, 127, 512, 31,
                                          COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX));
        pending_words.push_back(make_word(KIND_ACCUM, 127, 1, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 127, Z_MAX, Z_MAX, -1, -1, -1, -1));
        pending_words.push_back(make_word(KIND_ACCUM, 0, 0, 32, COEF_MAX, 0, COEF_MAX, 0));
        pending_words.push_back(make_word(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
        wait_until_drained();

        // With the Nyquist register at zero, z 0 is both the mean column and the
        // Nyquist column: weight one, or nothing at x 0; every other mode is dropped.
        write_z_nyquist(0);
        pending_words.push_back(make_word(KIND_ACCUM, 2, 0, 0,
                                          COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
        pending_words.push_back(make_word(KIND_ACCUM, 2, 3, 0,
                                          COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX));
        pending_words.push_back(make_word(KIND_ACCUM, 2, 3, 1, COEF_MAX, 1, COEF_MAX, 1));
        pending_words.push_back(make_word(KIND_READ, 2, 0, 0, 0, 0, 0, 0));
        push_random_words(90);
        // Starve the block once in mid phase until every read has come back.
        wait_until_drained();
        push_random_words(90);
        wait_until_drained();

        // Phase two: the sender idles often and the receiver rarely stalls.
        sender_idle_pct   = 45;
        receiver_idle_pct = 11;
        write_z_nyquist(Z_MAX);
        push_random_words(100);
        wait_until_drained();
        write_z_nyquist(1);
        push_random_words(100);
        wait_until_drained();

        // Phase three: no idling on either side, so words run back to back.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_z_nyquist(512);
        // Plane 5 takes a run of the largest interior addends and then one negative
        // edge-mode addend; the second read must find the plane cleared.
        repeat (LARGE_RUN_WORDS) begin
            pending_words.push_back(make_word(KIND_ACCUM, 5, 1, 100,
                                              COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
        end
        pending_words.push_back(make_word(KIND_ACCUM, 5, 1, 0, COEF_MIN, 0, COEF_MAX, 0));
        pending_words.push_back(make_word(KIND_READ, 5, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 5, 0, 0, 0, 0, 0, 0));
        // Plane 6 takes a run of the most negative interior addends.
        repeat (LARGE_RUN_WORDS) begin
            pending_words.push_back(make_word(KIND_ACCUM, 6, 7, 511,
                                              COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX));
        end
        pending_words.push_back(make_word(KIND_READ, 6, 0, 0, 0, 0, 0, 0));
        wait_until_drained();
        write_z_nyquist($urandom_range(511, 2));
        push_random_words(100);
        wait_until_drained();

        if (mismatch_count == 0) begin
            $display("spectral_plane_covariance_accumulator regression: pass");
        end else begin
            $display("spectral_plane_covariance_accumulator regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/spca_pkg.sv
rtl/spca_ram.sv
rtl/spca_mac.sv
rtl/spectral_plane_covariance_accumulator.sv
tb/sv/tb_top.sv
